### hw/rtl/bbr_pkg.sv
package bbr_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int ROW_W     = HGT_W + 1;
    localparam int LEAD_W    = COL_W + 2;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int NCH       = 4;
    localparam int NTAP      = 5;
    localparam int NLINE     = NTAP - 1;
    localparam int VCNT_W    = 3;
    localparam int CNT_W     = 5;
    localparam int SUM_W     = 11;
    localparam int HSUM_W    = 13;
    localparam int RCP_K     = 18;
    localparam int RCP_W     = 19;
    localparam int PROD_W    = 32;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd1024;

    // ceil(2^RCP_K / d) for divisors 1..25
    localparam logic [RCP_W-1:0] RECIP [0:25] = '{
        19'd0,      19'd262144, 19'd131072, 19'd87382,  19'd65536,
        19'd52429,  19'd43691,  19'd37450,  19'd32768,  19'd29128,
        19'd26215,  19'd23832,  19'd21846,  19'd20165,  19'd18725,
        19'd17477,  19'd16384,  19'd15421,  19'd14564,  19'd13798,
        19'd13108,  19'd12484,  19'd11916,  19'd11398,  19'd10923,
        19'd10486
    };

    typedef logic [NLINE-1:0][PIX_W-1:0] t_lines;

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] sum;
        logic [VCNT_W-1:0]         vcnt;
    } t_col;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             res;
        logic [COL_W-1:0] ocol;
        logic             last;
    } t_tick;

endpackage

### hw/rtl/bbr_in_if.sv
interface bbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha_in;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       filler;

    modport source (output valid, alpha_in, blue_in, green_in, red_in, filler, input ready);
    modport sink   (input valid, alpha_in, blue_in, green_in, red_in, filler, output ready);
endinterface

### hw/rtl/bbr_out_if.sv
interface bbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha_out;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_pixel;

    modport source (output valid, alpha_out, blue_out, green_out, red_out, last_pixel,
                    input ready);
    modport sink   (input valid, alpha_out, blue_out, green_out, red_out, last_pixel,
                    output ready);
endinterface

### hw/rtl/box_blur_5x5_rgba.sv
// A word passes the input register, window cells, sum register and product register.
// Throughput: one word per cycle unless stalled; the line store reads and writes once per word.
// A result word held on the output stalls the whole pipeline and the input.
// Results for position p leave with input word p + 2*width + 2; filler words drain the tail.
// Reset: synchronous active-low; clears counters and valids, width and height to 1024.
// The line store is not cleared; a window reads only entries written in its own frame.
module box_blur_5x5_rgba (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bbr_in_if.sink                      i_pix,
    bbr_out_if.source                   o_pix,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbr_pkg::ADDR_W-1:0]  paddr,
    input  logic [bbr_pkg::DATA_W-1:0]  pwdata,
    output logic [bbr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int COL_W  = bbr_pkg::COL_W;
    localparam int WID_W  = bbr_pkg::WID_W;
    localparam int HGT_W  = bbr_pkg::HGT_W;
    localparam int ROW_W  = bbr_pkg::ROW_W;
    localparam int LEAD_W = bbr_pkg::LEAD_W;
    localparam int NCH    = bbr_pkg::NCH;
    localparam int NTAP   = bbr_pkg::NTAP;
    localparam int SUM_W  = bbr_pkg::SUM_W;
    localparam int HSUM_W = bbr_pkg::HSUM_W;
    localparam int PROD_W = bbr_pkg::PROD_W;
    localparam int CH_W   = bbr_pkg::CH_W;
    localparam int PIX_W  = bbr_pkg::PIX_W;

    logic [WID_W-1:0]  r_fw;
    logic [HGT_W-1:0]  r_fh;
    logic [WID_W-1:0]  w;
    logic [HGT_W-1:0]  h;
    logic              cfg_wr;

    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [HGT_W-1:0]  r_out_row, n_out_row;
    logic [LEAD_W-1:0] r_lead, n_lead;
    logic [LEAD_W-1:0] lead_lim;

    logic              adv, accept, take, in_frame, res, last;
    bbr_pkg::t_tick    n_s1, r_s1;
    logic              r_s1_v;

    bbr_pkg::t_lines   rd;
    bbr_pkg::t_lines   wr_data;
    logic [NTAP-1:0][PIX_W-1:0] stack;
    logic [NTAP-1:0]   vmask;
    bbr_pkg::t_col     new_col;

    bbr_pkg::t_col     cols [NTAP+1];
    logic [NTAP-1:0]   hmask;
    logic [NCH-1:0][SUM_W-1:0] parts [NTAP];

    logic              r_s2_v, r_s2_last;
    logic [COL_W-1:0]  r_s2_ocol;
    logic [WID_W:0]    oc;

    logic [NCH-1:0][HSUM_W-1:0] n_s3_sum, r_s3_sum;
    logic [bbr_pkg::CNT_W-1:0]  n_s3_cnt, r_s3_cnt;
    logic              r_s3_v, r_s3_last;

    logic [NCH-1:0][PROD_W-1:0] r_o_prod;
    logic              r_o_v, r_o_last;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= bbr_pkg::WIDTH_RESET;
            r_fh <= bbr_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                bbr_pkg::REG_WIDTH:  r_fw <= pwdata[WID_W-1:0];
                bbr_pkg::REG_HEIGHT: r_fh <= pwdata[HGT_W-1:0];
                default:             r_fw <= r_fw;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bbr_pkg::REG_WIDTH:  prdata = {{(bbr_pkg::DATA_W-WID_W){1'b0}}, r_fw};
            bbr_pkg::REG_HEIGHT: prdata = {{(bbr_pkg::DATA_W-HGT_W){1'b0}}, r_fh};
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        if (r_fw == '0) begin
            w = WID_W'(1);
        end else if (r_fw > WID_W'(bbr_pkg::MAX_WIDTH)) begin
            w = WID_W'(bbr_pkg::MAX_WIDTH);
        end else begin
            w = r_fw;
        end
        h = (r_fh == '0) ? HGT_W'(1) : r_fh;
    end

    // input stage: position counters
    assign adv       = !r_o_v || o_pix.ready;
    assign i_pix.ready = adv;
    assign accept    = i_pix.valid && adv;
    assign in_frame  = r_in_row < ROW_W'(h);
    assign take      = accept && !(i_pix.filler && in_frame);
    assign lead_lim  = (LEAD_W'(w) << 1) + LEAD_W'(2);
    assign res       = r_lead >= lead_lim;
    assign last      = (r_out_row == h - HGT_W'(1))
                    && ({1'b0, r_out_col} == w - WID_W'(1));

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = r_lead;
        if (take) begin
            if ({1'b0, r_in_col} + WID_W'(1) >= w) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (!res) begin
                n_lead = r_lead + LEAD_W'(1);
            end else if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_lead    = '0;
            end else if ({1'b0, r_out_col} + WID_W'(1) >= w) begin
                n_out_col = '0;
                n_out_row = r_out_row + HGT_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
        n_s1.pix  = {i_pix.red_in, i_pix.green_in, i_pix.blue_in, i_pix.alpha_in};
        n_s1.col  = r_in_col;
        n_s1.row  = r_in_row;
        n_s1.res  = res;
        n_s1.ocol = r_out_col;
        n_s1.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= take;
        end
        if (adv) begin
            r_s1 <= n_s1;
        end
    end

    // line store: four earlier rows at each column
    bbr_line_store u_lines (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_rd_addr (r_in_col),
        .i_wr_en   (adv && r_s1_v),
        .i_wr_addr (r_s1.col),
        .i_wr_data (wr_data),
        .o_rd_data (rd)
    );

    always_comb begin
        stack[0] = r_s1.pix;
        for (int j = 1; j < NTAP; j++) begin
            stack[j] = rd[j-1];
        end
        wr_data[0] = r_s1.pix;
        for (int j = 1; j < bbr_pkg::NLINE; j++) begin
            wr_data[j] = rd[j-1];
        end
        for (int j = 0; j < NTAP; j++) begin
            vmask[j] = (r_s1.row >= ROW_W'(j))
                    && ((r_s1.row - ROW_W'(j)) < ROW_W'(h));
        end
        for (int c = 0; c < NCH; c++) begin
            new_col.sum[c] = '0;
            for (int j = 0; j < NTAP; j++) begin
                if (vmask[j]) begin
                    new_col.sum[c] = new_col.sum[c] + SUM_W'(stack[j][c*CH_W +: CH_W]);
                end
            end
        end
        new_col.vcnt = bbr_pkg::VCNT_W'($countones(vmask));
    end

    // window: five column cells, newest first
    assign cols[0] = new_col;
    assign oc      = {1'b0, r_s2_ocol};

    always_comb begin
        hmask[0] = oc + (WID_W+1)'(2) < {1'b0, w};
        hmask[1] = oc + (WID_W+1)'(1) < {1'b0, w};
        hmask[2] = 1'b1;
        hmask[3] = oc >= (WID_W+1)'(1);
        hmask[4] = oc >= (WID_W+1)'(2);
    end

    for (genvar i = 0; i < NTAP; i++) begin : g_cell
        bbr_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (adv && r_s1_v),
            .i_col  (cols[i]),
            .i_keep (hmask[i]),
            .o_col  (cols[i+1]),
            .o_part (parts[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s2_v <= r_s1_v && r_s1.res;
        end
        if (adv) begin
            r_s2_ocol <= r_s1.ocol;
            r_s2_last <= r_s1.last;
        end
    end

    // horizontal sum and divisor
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_s3_sum[c] = '0;
            for (int i = 0; i < NTAP; i++) begin
                n_s3_sum[c] = n_s3_sum[c] + HSUM_W'(parts[i][c]);
            end
        end
        n_s3_cnt = bbr_pkg::CNT_W'(cols[3].vcnt) * bbr_pkg::CNT_W'($countones(hmask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (adv) begin
            r_s3_v <= r_s2_v;
        end
        if (adv) begin
            r_s3_sum  <= n_s3_sum;
            r_s3_cnt  <= n_s3_cnt;
            r_s3_last <= r_s2_last;
        end
    end

    // divide by reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv) begin
            r_o_v <= r_s3_v;
        end
        if (adv) begin
            for (int c = 0; c < NCH; c++) begin
                r_o_prod[c] <= PROD_W'(r_s3_sum[c]) * PROD_W'(bbr_pkg::RECIP[r_s3_cnt]);
            end
            r_o_last <= r_s3_last;
        end
    end

    assign o_pix.valid      = r_o_v;
    assign o_pix.alpha_out  = r_o_prod[0][bbr_pkg::RCP_K +: CH_W];
    assign o_pix.blue_out   = r_o_prod[1][bbr_pkg::RCP_K +: CH_W];
    assign o_pix.green_out  = r_o_prod[2][bbr_pkg::RCP_K +: CH_W];
    assign o_pix.red_out    = r_o_prod[3][bbr_pkg::RCP_K +: CH_W];
    assign o_pix.last_pixel = r_o_last;

endmodule

### hw/rtl/bbr_line_store.sv
module bbr_line_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [bbr_pkg::COL_W-1:0] i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [bbr_pkg::COL_W-1:0] i_wr_addr,
    input  bbr_pkg::t_lines           i_wr_data,
    output bbr_pkg::t_lines           o_rd_data
);

    bbr_pkg::t_lines           r_mem [bbr_pkg::MAX_WIDTH];
    bbr_pkg::t_lines           r_rd;
    logic [bbr_pkg::COL_W-1:0] r_rd_addr;
    logic                      r_fwd_v;
    logic [bbr_pkg::COL_W-1:0] r_fwd_addr;
    bbr_pkg::t_lines           r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_rd      <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // forward the word written on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (i_wr_en) begin
            r_fwd_v <= 1'b1;
        end
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = (r_fwd_v && r_fwd_addr == r_rd_addr) ? r_fwd_data : r_rd;

endmodule

### hw/rtl/bbr_cell.sv
module bbr_cell (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  bbr_pkg::t_col                                i_col,
    input  logic                                         i_keep,
    output bbr_pkg::t_col                                o_col,
    output logic [bbr_pkg::NCH-1:0][bbr_pkg::SUM_W-1:0]  o_part
);

    bbr_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    always_comb begin
        for (int c = 0; c < bbr_pkg::NCH; c++) begin
            o_part[c] = i_keep ? r_col.sum[c] : '0;
        end
    end

endmodule

### hw/rtl/bbr_check.sv
module bbr_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last,
    input logic i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_last)))
        else $error("output word dropped while stalled");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind box_blur_5x5_rgba bbr_check u_bbr_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_last  (o_pix.last_pixel),
    .i_pready    (pready)
);
